[sv/dia_pkg.sv]
// Shared types and codes for the deadline interval assigner.
package dia_pkg;

  localparam int unsigned ValW = 6;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NONE   = 2'd1;
  localparam logic [1:0] STATUS_MISSED = 2'd2;
  localparam logic [1:0] STATUS_FAILED = 2'd3;

  typedef struct packed {
    logic [1:0]      op;
    logic [ValW-1:0] interval_start;
    logic [ValW-1:0] interval_end;
  } in_t;

  typedef struct packed {
    logic [ValW-1:0] assigned_item;
    logic [1:0]      status;
    logic            last_place;
  } out_t;

  // Best candidate seen so far, handed from cell to cell.
  typedef struct packed {
    logic            found;
    logic [ValW-1:0] cand_end;
    logic [ValW-1:0] cand_start;
  } cand_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic            clear;
    logic            wr_en;
    logic [ValW-1:0] wr_start;
    logic [ValW-1:0] wr_end;
    logic            mark_en;
  } cell_ctl_t;

endpackage

[sv/dia_cell.sv]
// One storage cell: holds an interval and forwards the better candidate.
module dia_cell #(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned IDX       = 0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dia_pkg::cell_ctl_t             ctl_i,
  input  logic [$clog2(MAX_ITEMS)-1:0]   wr_idx_i,
  input  logic [$clog2(MAX_ITEMS)-1:0]   mark_idx_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0] loaded_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0] place_i,
  input  dia_pkg::cand_t                 cand_i,
  input  logic [$clog2(MAX_ITEMS)-1:0]   cand_idx_i,
  output dia_pkg::cand_t                 cand_o,
  output logic [$clog2(MAX_ITEMS)-1:0]   cand_idx_o
);

  localparam int unsigned IdxW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CmpW = (CntW > dia_pkg::ValW) ? CntW : dia_pkg::ValW;
  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);
  localparam logic [CntW-1:0] MyCnt = CntW'(IDX);

  logic [dia_pkg::ValW-1:0] start_q;
  logic [dia_pkg::ValW-1:0] end_q;
  logic                     taken_q;
  dia_pkg::cand_t           cand_q;
  logic [IdxW-1:0]          cand_idx_q;

  logic eligible;
  logic better;

  always_comb begin
    eligible = (MyCnt < loaded_i) && !taken_q && (CmpW'(start_q) <= CmpW'(place_i));
    better   = !cand_i.found || (end_q < cand_i.cand_end) ||
               ((end_q == cand_i.cand_end) && (start_q < cand_i.cand_start));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en && (wr_idx_i == MyIdx)) begin
      start_q <= ctl_i.wr_start;
      end_q   <= ctl_i.wr_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q    <= 1'b0;
      cand_q     <= '0;
      cand_idx_q <= '0;
    end else begin
      if (ctl_i.clear || (ctl_i.wr_en && (wr_idx_i == MyIdx))) begin
        taken_q <= 1'b0;
      end else if (ctl_i.mark_en && (mark_idx_i == MyIdx)) begin
        taken_q <= 1'b1;
      end
      // Strictly better only, so the lower index wins a full tie.
      if (eligible && better) begin
        cand_q     <= '{found: 1'b1, cand_end: end_q, cand_start: start_q};
        cand_idx_q <= MyIdx;
      end else begin
        cand_q     <= cand_i;
        cand_idx_q <= cand_idx_i;
      end
    end
  end

  assign cand_o     = cand_q;
  assign cand_idx_o = cand_idx_q;

endmodule

[sv/deadline_interval_assigner_unit.sv]
// Top level of the deadline interval assigner: cell chain and controller.

// Intervals are loaded into a chain of MAX_ITEMS cells, one transaction per
// cycle while busy is low, and each tick assigns the current place to the
// eligible interval with the least end, then least start, then least index.
// A load, a clear, a tick past the loaded set and a tick after a failure are
// handled in idle without a scan; the tick after a failure shows its result
// in the next cycle. Any other tick runs a candidate wave through the whole
// cell chain, one cell per cycle, with busy high until the wave is through;
// the result appears in the first cycle with busy low, and the next
// transaction can be taken as soon as busy is low. Each result is shown for
// exactly one cycle with result_valid_o high and must be taken then.
module deadline_interval_assigner_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dia_pkg::in_t  item_i,
  output logic          result_valid_o,
  output dia_pkg::out_t result_o
);

  localparam int unsigned IdxW  = $clog2(MAX_ITEMS);
  localparam int unsigned CntW  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CmpW  = (CntW > dia_pkg::ValW) ? CntW : dia_pkg::ValW;
  localparam int unsigned WideW = (IdxW > dia_pkg::ValW) ? IdxW : dia_pkg::ValW;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    scan_cnt_q;
  logic [CntW-1:0]    loaded_q;
  logic [CntW-1:0]    place_q;
  logic               failed_q;
  logic               result_valid_q;
  dia_pkg::out_t      result_q;

  dia_pkg::cell_ctl_t ctl;
  dia_pkg::cand_t     cand   [0:MAX_ITEMS];
  logic [IdxW-1:0]    cand_idx [0:MAX_ITEMS];

  logic               accept;
  logic               scan_done;
  logic               missed;
  logic               last_place;
  logic [WideW-1:0]   best_wide;
  dia_pkg::out_t      scan_result;

  assign accept    = start && (state_q == ST_IDLE);
  assign scan_done = (state_q == ST_SCAN) && (scan_cnt_q == '0);

  assign cand[0]     = '0;
  assign cand_idx[0] = '0;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    dia_cell #(
      .MAX_ITEMS (MAX_ITEMS),
      .IDX       (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .wr_idx_i   (loaded_q[IdxW-1:0]),
      .mark_idx_i (cand_idx[MAX_ITEMS]),
      .loaded_i   (loaded_q),
      .place_i    (place_q),
      .cand_i     (cand[g]),
      .cand_idx_i (cand_idx[g]),
      .cand_o     (cand[g+1]),
      .cand_idx_o (cand_idx[g+1])
    );
  end

  always_comb begin
    missed     = CmpW'(cand[MAX_ITEMS].cand_end) < CmpW'(place_q);
    last_place = (place_q + 1'b1) == loaded_q;
    best_wide  = WideW'(cand_idx[MAX_ITEMS]);

    scan_result.last_place = last_place;
    if (!cand[MAX_ITEMS].found) begin
      scan_result.assigned_item = '0;
      scan_result.status        = dia_pkg::STATUS_NONE;
    end else begin
      scan_result.assigned_item = best_wide[dia_pkg::ValW-1:0];
      scan_result.status        = missed ? dia_pkg::STATUS_MISSED : dia_pkg::STATUS_OK;
    end

    ctl.clear    = accept && (item_i.op == dia_pkg::OP_CLEAR);
    ctl.wr_en    = accept && (item_i.op == dia_pkg::OP_LOAD) &&
                   (loaded_q < CntW'(MAX_ITEMS));
    ctl.wr_start = item_i.interval_start;
    ctl.wr_end   = item_i.interval_end;
    ctl.mark_en  = scan_done && cand[MAX_ITEMS].found && !missed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      scan_cnt_q     <= '0;
      loaded_q       <= '0;
      place_q        <= '0;
      failed_q       <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            case (item_i.op)
              dia_pkg::OP_LOAD: begin
                if (ctl.wr_en) begin
                  loaded_q <= loaded_q + 1'b1;
                end
              end
              dia_pkg::OP_TICK: begin
                if (place_q < loaded_q) begin
                  if (failed_q) begin
                    result_valid_q <= 1'b1;
                    result_q       <= '{assigned_item: '0,
                                        status: dia_pkg::STATUS_FAILED,
                                        last_place: last_place};
                    place_q        <= place_q + 1'b1;
                  end else begin
                    // The scan waits for the candidate wave to pass through every cell of the chain.
                    state_q    <= ST_SCAN;
                    scan_cnt_q <= CntW'(MAX_ITEMS);
                  end
                end
              end
              dia_pkg::OP_CLEAR: begin
                loaded_q <= '0;
                place_q  <= '0;
                failed_q <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_cnt_q == '0) begin
            state_q        <= ST_IDLE;
            result_valid_q <= 1'b1;
            result_q       <= scan_result;
            place_q        <= place_q + 1'b1;
            if (scan_result.status != dia_pkg::STATUS_OK) begin
              failed_q <= 1'b1;
            end
          end else begin
            scan_cnt_q <= scan_cnt_q - 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // A successful assignment never coexists with a recorded failure.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status == dia_pkg::STATUS_OK)) |-> !failed_q)
    else $error("ok result while failure is recorded");

  // A failed-earlier result needs a failure on record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status == dia_pkg::STATUS_FAILED)) |-> failed_q)
    else $error("failed-earlier result without recorded failure");

  // The place counter never runs past the loaded set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    place_q <= loaded_q)
    else $error("place counter beyond loaded count");

  // A result follows either a finished scan or a tick taken in idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(scan_done) || ($past(accept) &&
                       ($past(item_i.op) == dia_pkg::OP_TICK))))
    else $error("result without a tick");

endmodule
